// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, held off during reset
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising edge, held off during reset
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mts_pkg.sv =====
`default_nettype none

package mts_pkg;

    localparam int VAL_W  = 32;
    localparam int FILL_W = 11;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_POP_EMPTY = 2'd1;
    localparam logic [1:0] STS_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       push;
        logic       pop;
        logic       load;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic single;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mts_ram.sv =====
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mts_ctrl.sv =====
`default_nettype none

module mts_ctrl
    import mts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_opcode,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output logic      in_ready,
    output logic      out_valid,
    output cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cmd.status = STS_OK;
                    if (in_opcode == OP_PUSH)
                    begin
                        if (sts.full)
                        begin
                            cmd.status = STS_PUSH_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                        state_next = ST_OUT;
                    end
                    else if (sts.empty)
                    begin
                        cmd.status = STS_POP_EMPTY;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = sts.single ? ST_OUT : ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.load   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

endmodule

`default_nettype wire

// ===== rtl/core/mts_dpath.sv =====
`default_nettype none

module mts_dpath
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    input  wire logic signed [VAL_W-1:0]  push_value,
    output sts_t                          sts,
    output logic signed [VAL_W-1:0]       top_value,
    output logic signed [VAL_W-1:0]       min_value,
    output logic                          is_empty,
    output logic [FILL_W-1:0]             fill_count,
    output logic [1:0]                    status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic signed [VAL_W-1:0]   top_val_reg;
    logic signed [VAL_W-1:0]   top_min_reg;
    logic [1:0]                status_reg;
    logic signed [VAL_W-1:0]   new_min;
    logic [AW-1:0]             below_idx;
    logic                      rd_en;
    logic [2*VAL_W-1:0]        rd_data;

    assign sts.empty  = (count_reg == '0);
    assign sts.full   = (count_reg == CW'(STACK_DEPTH));
    assign sts.single = (count_reg == CW'(1));

    assign new_min   = (!sts.empty && (top_min_reg < push_value)) ? top_min_reg : push_value;
    assign below_idx = AW'(count_reg - CW'(2));
    assign rd_en     = cmd.pop && !sts.single;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    mts_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (count_reg[AW-1:0]),
        .wdata ({new_min, push_value}),
        .re    (rd_en),
        .raddr (below_idx),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.push)
        begin
            top_val_reg <= push_value;
            top_min_reg <= new_min;
        end
        else if (cmd.load)
        begin
            top_val_reg <= rd_data[VAL_W-1:0];
            top_min_reg <= rd_data[2*VAL_W-1:VAL_W];
        end
    end

    assign is_empty   = sts.empty;
    assign top_value  = sts.empty ? '0 : top_val_reg;
    assign min_value  = sts.empty ? '0 : top_min_reg;
    assign fill_count = FILL_W'(count_reg);
    assign status     = status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/min_tracking_stack.sv =====
// Min-tracking stack of signed 32-bit words.
// Input channel s_*: one word per operation, s_tuser = opcode (push or pop),
// s_tdata = value to push. Output channel m_*: one word per operation giving
// the top value, running minimum, empty flag and fill count after the
// operation, with m_tuser = status (ok, pop on empty, push on full).
// The top entry is held in registers; lower entries sit in a simple
// dual-port RAM (one write port, one read port) with registered read.
// A push, a rejected operation or a pop that empties the stack shows its
// result in the cycle after acceptance; a pop that uncovers a lower entry
// first passes through a read state in which the RAM read refills the top.
// One operation is in flight at a time: s_tready rises again the cycle after
// the result is taken, so a new operation is not accepted until the last
// result has been taken.
// A stalled result holds on m_tdata/m_tuser and s_tready stays low.
// Reset empties the stack at once; no clearing pass is run over the RAM.
`default_nettype none

module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] push_value
    input  wire logic        s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [31:0] top_value, [63:32] min_value,
                                        // [64] is_empty, [75:65] fill_count, [79:76] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    cmd_t                    cmd;
    sts_t                    sts;
    logic signed [VAL_W-1:0] top_value;
    logic signed [VAL_W-1:0] min_value;
    logic                    is_empty;
    logic [FILL_W-1:0]       fill_count;

    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser),
        .out_ready (m_tready),
        .sts       (sts),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd)
    );

    mts_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_value (s_tdata),
        .sts        (sts),
        .top_value  (top_value),
        .min_value  (min_value),
        .is_empty   (is_empty),
        .fill_count (fill_count),
        .status     (m_tuser)
    );

    assign m_tdata = {4'd0, fill_count, is_empty, min_value, top_value};

endmodule

`default_nettype wire

// ===== rtl/core/mts_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module mts_checker
    import mts_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    logic out_stall;
    logic out_take;

    assign out_stall = m_tvalid && !m_tready;
    assign out_take  = m_tvalid && m_tready;

    `MTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `MTS_ASSERT_NOW(a_one_in_flight, clk, rst_n, m_tvalid, !s_tready)
    `MTS_ASSERT_NEXT(a_ready_after_take, clk, rst_n, out_take, s_tready)
    `MTS_ASSERT_NOW(a_empty_zero, clk, rst_n, m_tvalid && (m_tdata[64] || m_tuser == STS_POP_EMPTY), m_tdata[63:0] == 64'd0 && m_tdata[64])

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

`default_nettype wire

// ===== dv/tb_min_tracking_stack.sv =====
`timescale 1ns / 1ps

module tb_min_tracking_stack;
    import mts_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int TAIL_WORDS = 150;
    localparam int CALM_SPAN  = 80;
    localparam int WDOG_LIMIT = 2000;

    typedef struct packed {
        logic        op;
        logic [31:0] value;
    } stack_op_t;

    typedef struct packed {
        logic [31:0] top_value;
        logic [31:0] min_value;
        logic        is_empty;
        logic [10:0] fill_count;
        logic [1:0]  status;
    } stack_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = OP_PUSH;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    stack_op_t   pending_ops[$];
    stack_view_t expected_views[$];
    stack_op_t   next_op;
    stack_view_t want;

    logic [31:0] stack_vals[DEPTH];
    logic [31:0] stack_mins[DEPTH];
    int          held = 0;
    int          plan_depth = 0;

    int total_words = 0;
    int words_in = 0;
    int words_out = 0;
    int send_gap = 0;
    int stall_left = 0;
    int stalled_cycles = 0;
    int fail_count = 0;
    int push_count = 0;
    int pop_count = 0;
    int full_pushes = 0;
    int empty_pops = 0;
    int deepest = 0;

    min_tracking_stack #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic stack_view_t stack_apply(input logic op, input logic [31:0] value);
        stack_view_t v;
        logic [31:0] run_min;
        v.status = STS_OK;
        if (op == OP_PUSH) begin
            push_count++;
            if (held >= DEPTH) begin
                v.status = STS_PUSH_FULL;
                full_pushes++;
            end
            else begin
                run_min = value;
                if (held > 0 && $signed(stack_mins[held-1]) < $signed(value))
                    run_min = stack_mins[held-1];
                stack_vals[held] = value;
                stack_mins[held] = run_min;
                held++;
            end
        end
        else begin
            pop_count++;
            if (held == 0) begin
                v.status = STS_POP_EMPTY;
                empty_pops++;
            end
            else begin
                held--;
            end
        end
        if (held > deepest)
            deepest = held;
        if (held > 0) begin
            v.top_value = stack_vals[held-1];
            v.min_value = stack_mins[held-1];
            v.is_empty  = 1'b0;
        end
        else begin
            v.top_value = '0;
            v.min_value = '0;
            v.is_empty  = 1'b1;
        end
        v.fill_count = held[10:0];
        return v;
    endfunction

    function automatic bit idling_allowed(input int n);
        return n < total_words - TAIL_WORDS && (n / CALM_SPAN) % 4 != 3;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 16)) - 32'd8;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h8000_0000 + 32'($urandom_range(0, 3));
                    default: v = 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
                endcase
            end
            default: v = 32'(1000 - 3 * plan_depth) + 32'($urandom_range(0, 5));
        endcase
        return v;
    endfunction

    task automatic add_op(input logic op, input logic [31:0] value);
        stack_op_t item;
        item.op    = op;
        item.value = value;
        pending_ops.push_back(item);
        if (op == OP_PUSH && plan_depth < DEPTH)
            plan_depth++;
        else if (op == OP_POP && plan_depth > 0)
            plan_depth--;
    endtask

    task automatic add_mix(input int count, input int push_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1, 100) <= push_pct)
                add_op(OP_PUSH, pick_value());
            else
                add_op(OP_POP, $urandom);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_word();
        if (expected_views.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual tdata %h tuser %h",
                     $time, m_tdata, m_tuser);
            fail_count++;
        end
        else begin
            want = expected_views.pop_front();
            compare_field("top_value", want.top_value, m_tdata[31:0]);
            compare_field("min_value", want.min_value, m_tdata[63:32]);
            compare_field("is_empty", 32'(want.is_empty), 32'(m_tdata[64]));
            compare_field("fill_count", 32'(want.fill_count), 32'(m_tdata[75:65]));
            compare_field("padding", 32'd0, 32'(m_tdata[79:76]));
            compare_field("status", 32'(want.status), 32'(m_tuser));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_PUSH;
            send_gap = 0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                expected_views.push_back(stack_apply(s_tuser, s_tdata));
                words_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_ops.size() > 0 && idling_allowed(words_in)
                         && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 10);
                    s_tvalid <= 1'b0;
                end
                else if (pending_ops.size() > 0) begin
                    next_op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_op.op;
                    s_tdata  <= next_op.value;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                check_word();
                words_out++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idling_allowed(words_out) && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, WDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        add_op(OP_POP, 32'h0000_0000);
        add_op(OP_POP, 32'hFFFF_FFFF);
        add_op(OP_PUSH, 32'h0000_0000);
        add_op(OP_PUSH, 32'h7FFF_FFFF);
        add_op(OP_PUSH, 32'h8000_0000);
        add_op(OP_PUSH, 32'h7FFF_FFFF);
        add_op(OP_POP, 32'h1234_5678);
        add_op(OP_POP, 32'h0000_0000);
        add_op(OP_PUSH, 32'hFFFF_FFFF);
        add_op(OP_PUSH, 32'h0000_0001);
        add_op(OP_PUSH, 32'hFFFF_FFFF);
        add_op(OP_POP, 32'h0000_0000);
        add_op(OP_POP, 32'h0000_0000);
        add_op(OP_POP, 32'h0000_0000);
        add_op(OP_POP, 32'h0000_0000);
        add_op(OP_POP, 32'h0000_0000);
        add_op(OP_PUSH, 32'h0000_0005);
        add_op(OP_PUSH, 32'h0000_0005);
        add_op(OP_PUSH, 32'h0000_0004);
        add_op(OP_POP, 32'h0000_0000);
        add_op(OP_POP, 32'h0000_0000);
        add_op(OP_POP, 32'h0000_0000);
        add_op(OP_POP, 32'h0000_0000);

        add_mix(200, 55);
        while (plan_depth < DEPTH)
            add_op(OP_PUSH, pick_value());
        repeat (10)
            add_op(OP_PUSH, pick_value());
        add_mix(60, 50);
        add_mix(60, 20);
        total_words = pending_ops.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (words_in < total_words || expected_views.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (expected_views.size() > 0) begin
            $display("%0t: %0d results never arrived", $time, expected_views.size());
            fail_count++;
        end
        $display("Ran %0d operations: %0d pushes (%0d on a full stack), %0d pops (%0d on empty)",
                 words_in, push_count, full_pushes, pop_count, empty_pops);
        $display("Deepest fill %0d of %0d entries, %0d results checked, %0d mismatches",
                 deepest, DEPTH, words_out, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
